// ===== rtl/fau_pkg.sv =====
// ----------------------------------------------------------------------------
// fau_pkg
// Shared types, codes and defaults of the feature accumulator update core.
// ----------------------------------------------------------------------------
package fau_pkg;

   localparam int NEURONS_DEFAULT      = 128;
   localparam int FEATURE_ROWS_DEFAULT = 3072;

   localparam int CMD_WIDTH    = 3;
   localparam int ROW_WIDTH    = 12;
   localparam int ELEM_WIDTH   = 7;
   localparam int WORD_WIDTH   = 16;
   localparam int CLIP_WIDTH   = 15;
   localparam int SHIFT_WIDTH  = 4;
   localparam int OUT_WIDTH    = 8;
   localparam int PROD_WIDTH   = 2 * CLIP_WIDTH;
   localparam int REQ_BITS     = 1 + 1 + ROW_WIDTH + ELEM_WIDTH + WORD_WIDTH;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CLIP_WIDTH-1:0]  CLIP_RESET  = CLIP_WIDTH'(255);
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = SHIFT_WIDTH'(9);

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MAX      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_SHIFT = 1'b1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE_WEIGHT = 3'd0,
      CMD_WRITE_BIAS   = 3'd1,
      CMD_SET_BIAS     = 3'd2,
      CMD_ADD_ROW      = 3'd3,
      CMD_SUB_ROW      = 3'd4,
      CMD_ACTIVATE     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ALU_PASS  = 2'd0,
      ALU_ADD   = 2'd1,
      ALU_SUB   = 2'd2,
      ALU_CLAMP = 2'd3
   } alu_op_type;

   typedef struct packed {
      alu_op_type            op;
      logic [CLIP_WIDTH-1:0] clip;
   } alu_ctl_type;

endpackage

// ===== rtl/fau_ram.sv =====
// ----------------------------------------------------------------------------
// fau_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fau_alu.sv =====
// ----------------------------------------------------------------------------
// fau_alu
// Shared word unit: pass, wraparound add and subtract, clamp to [0, clip].
// ----------------------------------------------------------------------------
module fau_alu (
   input  fau_pkg::alu_ctl_type              ctl,
   input  logic [fau_pkg::WORD_WIDTH-1:0]    a,
   input  logic [fau_pkg::WORD_WIDTH-1:0]    b,
   output logic [fau_pkg::WORD_WIDTH-1:0]    result
);

   always_comb begin
      case (ctl.op)
         fau_pkg::ALU_PASS: result = b;
         fau_pkg::ALU_ADD:  result = a + b;
         fau_pkg::ALU_SUB:  result = a - b;
         fau_pkg::ALU_CLAMP: begin
            if (a[fau_pkg::WORD_WIDTH-1]) begin
               result = '0;
            end else if (a[fau_pkg::CLIP_WIDTH-1:0] > ctl.clip) begin
               result = fau_pkg::WORD_WIDTH'(ctl.clip);
            end else begin
               result = a;
            end
         end
         default: result = b;
      endcase
   end

endmodule

// ===== rtl/feature_accumulator_update_core.sv =====
// ----------------------------------------------------------------------------
// feature_accumulator_update_core
// Incremental accumulator of a quantized feature transformer: weight, bias and
// a two-half accumulator memory driven by a sequencer around one word unit.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req     | in        | tuser command, tdata perspective..word_value
//  rsp     | out       | tdata out_byte, one beat per activate
//  csr     | in        | index and data of clip_max or product_shift
//
//  Writes pass through a single write state; set to bias, add and subtract
//  row run one element per cycle through the accumulator memory port.
//  Activate steps through two accumulator reads, a multiply and the output.
//  Reset is synchronous; memories hold no reset state.
//  req_tready is high only in idle; a stalled rsp holds activate in its
//  output step.
// ----------------------------------------------------------------------------
module feature_accumulator_update_core #(
   parameter int NEURONS      = fau_pkg::NEURONS_DEFAULT,
   parameter int FEATURE_ROWS = fau_pkg::FEATURE_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] perspective, [1] side_to_move, [13:2] feature_row,
   // [20:14] element_index, [36:21] word_value
   input  logic [fau_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] command
   input  logic [fau_pkg::CMD_WIDTH-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] out_byte
   output logic [fau_pkg::OUT_WIDTH-1:0]       rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fau_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fau_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NIDX = $clog2(NEURONS);
   localparam int CW   = NIDX + 1;
   localparam int HALF = NEURONS / 2;
   localparam int AAW  = $clog2(2 * NEURONS);
   localparam int WAW  = $clog2(FEATURE_ROWS * NEURONS);
   localparam int FRW  = $clog2(FEATURE_ROWS + 1);
   localparam int RW   = ((FRW > fau_pkg::ROW_WIDTH) ? FRW : fau_pkg::ROW_WIDTH) + 1;
   localparam int EW   = ((NIDX > fau_pkg::ELEM_WIDTH) ? NIDX : fau_pkg::ELEM_WIDTH) + 1;
   localparam int WW   = fau_pkg::WORD_WIDTH;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_WRITE   = 7'b0000010,
      S_COPY    = 7'b0000100,
      S_UPDATE  = 7'b0001000,
      S_ACT_LO  = 7'b0010000,
      S_ACT_HI  = 7'b0100000,
      S_ACT_MUL = 7'b1000000
   } state_type;

   function automatic logic [AAW-1:0] acc_addr(input logic side, input logic [NIDX-1:0] idx);
      acc_addr = side ? AAW'(idx) + AAW'(NEURONS) : AAW'(idx);
   endfunction

   state_type                          state_ff, state_in;
   logic                               act_out_ff, act_out_in;
   fau_pkg::cmd_type                   cmd_ff, cmd_in;
   logic                               persp_ff, persp_in;
   logic                               side_ff, side_in;
   logic [NIDX-1:0]                    elem_ff, elem_in;
   logic [NIDX-1:0]                    aidx_ff, aidx_in;
   logic [WW-1:0]                      word_ff, word_in;
   logic [WAW-1:0]                     base_ff, base_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic                               pend_ff, pend_in;
   logic [NIDX-1:0]                    pidx_ff, pidx_in;
   logic [fau_pkg::CLIP_WIDTH-1:0]     c0_ff, c0_in;
   logic [fau_pkg::PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic [fau_pkg::CLIP_WIDTH-1:0]     clip_ff, clip_in;
   logic [fau_pkg::SHIFT_WIDTH-1:0]    shift_ff, shift_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [fau_pkg::OUT_WIDTH-1:0]      rsp_data_ff, rsp_data_in;

   logic                               req_fire;
   logic                               r_persp, r_stm;
   logic [fau_pkg::ROW_WIDTH-1:0]      r_row;
   logic [fau_pkg::ELEM_WIDTH-1:0]     r_elem;
   logic [WW-1:0]                      r_word;
   logic                               row_ok, elem_ok, elem_low;
   logic [fau_pkg::PROD_WIDTH-1:0]     shifted;

   logic                               weight_we, bias_we, acc_we;
   logic [WAW-1:0]                     weight_waddr, weight_raddr;
   logic [NIDX-1:0]                    bias_raddr;
   logic [AAW-1:0]                     acc_waddr, acc_raddr;
   logic [WW-1:0]                      weight_rdata, bias_rdata, acc_rdata;
   logic [WW-1:0]                      alu_b, alu_result;
   fau_pkg::alu_ctl_type               alu_ctl;

   assign req_tready = (state_ff == S_IDLE) && !act_out_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign r_persp = req_tdata[0];
   assign r_stm   = req_tdata[1];
   assign r_row   = req_tdata[13:2];
   assign r_elem  = req_tdata[20:14];
   assign r_word  = req_tdata[36:21];

   assign row_ok   = RW'(r_row) < RW'(FEATURE_ROWS);
   assign elem_ok  = EW'(r_elem) < EW'(NEURONS);
   assign elem_low = EW'(r_elem) < EW'(HALF);
   assign shifted  = prod_ff >> shift_ff;

   always_comb begin
      clip_in  = clip_ff;
      shift_in = shift_ff;
      if (csr_valid) begin
         case (csr_index)
            fau_pkg::CSR_CLIP_MAX:      clip_in  = csr_data[fau_pkg::CLIP_WIDTH-1:0];
            fau_pkg::CSR_PRODUCT_SHIFT: shift_in = csr_data[fau_pkg::SHIFT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_out_in   = act_out_ff;
      cmd_in       = cmd_ff;
      persp_in     = persp_ff;
      side_in      = side_ff;
      elem_in      = elem_ff;
      aidx_in      = aidx_ff;
      word_in      = word_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      c0_in        = c0_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (act_out_ff) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = (|shifted[fau_pkg::PROD_WIDTH-1:fau_pkg::OUT_WIDTH])
                           ? '1 : shifted[fau_pkg::OUT_WIDTH-1:0];
            act_out_in   = 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  cmd_in   = fau_pkg::cmd_type'(req_tuser);
                  persp_in = r_persp;
                  elem_in  = NIDX'(r_elem);
                  word_in  = r_word;
                  base_in  = WAW'(WAW'(r_row) * WAW'(NEURONS));
                  cnt_in   = '0;
                  side_in  = elem_low ? r_stm : !r_stm;
                  aidx_in  = elem_low ? NIDX'(r_elem) : NIDX'(EW'(r_elem) - EW'(HALF));
                  case (fau_pkg::cmd_type'(req_tuser))
                     fau_pkg::CMD_WRITE_WEIGHT: begin
                        if (row_ok && elem_ok) state_in = S_WRITE;
                     end
                     fau_pkg::CMD_WRITE_BIAS: begin
                        if (elem_ok) state_in = S_WRITE;
                     end
                     fau_pkg::CMD_SET_BIAS: state_in = S_COPY;
                     fau_pkg::CMD_ADD_ROW, fau_pkg::CMD_SUB_ROW: begin
                        if (row_ok) state_in = S_UPDATE;
                     end
                     fau_pkg::CMD_ACTIVATE: begin
                        if (elem_ok) begin
                           state_in = S_ACT_LO;
                        end else begin
                           prod_in    = '0;
                           act_out_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_WRITE: state_in = S_IDLE;
            S_COPY, S_UPDATE: begin
               if (cnt_ff < CW'(NEURONS)) begin
                  pend_in = 1'b1;
                  pidx_in = cnt_ff[NIDX-1:0];
                  cnt_in  = cnt_ff + CW'(1);
               end else if (!pend_ff) begin
                  state_in = S_IDLE;
               end
            end
            S_ACT_LO: state_in = S_ACT_HI;
            S_ACT_HI: begin
               c0_in    = alu_result[fau_pkg::CLIP_WIDTH-1:0];
               state_in = S_ACT_MUL;
            end
            S_ACT_MUL: begin
               prod_in    = fau_pkg::PROD_WIDTH'(c0_ff) *
                            fau_pkg::PROD_WIDTH'(alu_result[fau_pkg::CLIP_WIDTH-1:0]);
               state_in   = S_IDLE;
               act_out_in = 1'b1;
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_out_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= fau_pkg::CLIP_RESET;
         shift_ff     <= fau_pkg::SHIFT_RESET;
      end else begin
         state_ff     <= state_in;
         act_out_ff   <= act_out_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_ff      <= clip_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      persp_ff    <= persp_in;
      side_ff     <= side_in;
      elem_ff     <= elem_in;
      aidx_ff     <= aidx_in;
      word_ff     <= word_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      pidx_ff     <= pidx_in;
      c0_ff       <= c0_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign weight_we    = (state_ff == S_WRITE) && (cmd_ff == fau_pkg::CMD_WRITE_WEIGHT);
   assign bias_we      = (state_ff == S_WRITE) && (cmd_ff == fau_pkg::CMD_WRITE_BIAS);
   assign weight_waddr = base_ff + WAW'(elem_ff);
   assign weight_raddr = base_ff + WAW'(cnt_ff[NIDX-1:0]);
   assign bias_raddr   = cnt_ff[NIDX-1:0];
   assign acc_we       = pend_ff;
   assign acc_waddr    = acc_addr(persp_ff, pidx_ff);

   always_comb begin
      case (state_ff)
         S_ACT_LO: acc_raddr = acc_addr(side_ff, aidx_ff);
         S_ACT_HI: acc_raddr = acc_addr(side_ff, aidx_ff + NIDX'(HALF));
         default:  acc_raddr = acc_addr(persp_ff, cnt_ff[NIDX-1:0]);
      endcase
   end

   always_comb begin
      alu_ctl.clip = clip_ff;
      case (state_ff)
         S_COPY:   alu_ctl.op = fau_pkg::ALU_PASS;
         S_UPDATE: alu_ctl.op = (cmd_ff == fau_pkg::CMD_SUB_ROW) ? fau_pkg::ALU_SUB
                                                                 : fau_pkg::ALU_ADD;
         S_ACT_HI, S_ACT_MUL: alu_ctl.op = fau_pkg::ALU_CLAMP;
         default:  alu_ctl.op = fau_pkg::ALU_PASS;
      endcase
   end

   assign alu_b = (state_ff == S_COPY) ? bias_rdata : weight_rdata;

   fau_alu u_alu (
      .ctl    (alu_ctl),
      .a      (acc_rdata),
      .b      (alu_b),
      .result (alu_result)
   );

   fau_ram #(.WIDTH(WW), .DEPTH(FEATURE_ROWS * NEURONS)) u_weight_ram (
      .clock (clock),
      .we    (weight_we),
      .waddr (weight_waddr),
      .wdata (word_ff),
      .raddr (weight_raddr),
      .rdata (weight_rdata)
   );

   fau_ram #(.WIDTH(WW), .DEPTH(NEURONS)) u_bias_ram (
      .clock (clock),
      .we    (bias_we),
      .waddr (elem_ff),
      .wdata (word_ff),
      .raddr (bias_raddr),
      .rdata (bias_rdata)
   );

   fau_ram #(.WIDTH(WW), .DEPTH(2 * NEURONS)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (alu_result),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("accumulator write pending in idle");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY || state_ff == S_UPDATE) |-> (cnt_ff <= CW'(NEURONS)))
      else $error("element counter beyond row length");

   a_acc_we_state: assert property (@(posedge clock) disable iff (reset)
      acc_we |-> (state_ff == S_COPY || state_ff == S_UPDATE))
      else $error("accumulator written outside a row sweep");

   a_rsp_from_act: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(act_out_ff))
      else $error("response raised without activate");

endmodule

// ===== dv/feature_accumulator_update_core_tb.sv =====
// ----------------------------------------------------------------------------
// feature_accumulator_update_core_tb
// Self-checking bench for the feature accumulator update core. It loads the
// bias row and a few complete weight rows, runs a short table of hand-picked
// commands, then random command streams under several clamp and shift
// settings. Each activate byte is checked against the table byte if given,
// else a model of the weight, bias and accumulator memories. Both stream sides
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module feature_accumulator_update_core_tb;

   localparam int NEURONS       = fau_pkg::NEURONS_DEFAULT;
   localparam int FEATURE_ROWS  = fau_pkg::FEATURE_ROWS_DEFAULT;
   localparam int HALF          = NEURONS / 2;
   localparam int SETTLE_CYCLES = NEURONS + 32;
   localparam int PHASES        = 6;
   localparam int PHASE_BEATS   = 165;
   localparam int LONG_HOLD_AT  = 60;
   localparam int LONG_HOLD     = 600;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int DIRECTED_ROWS = 25;

   localparam logic [fau_pkg::CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [fau_pkg::CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [fau_pkg::CMD_WIDTH-1:0]  cmd;
      logic                           persp;
      logic                           stm;
      logic [fau_pkg::ROW_WIDTH-1:0]  row;
      logic [fau_pkg::ELEM_WIDTH-1:0] elem;
      logic [fau_pkg::WORD_WIDTH-1:0] word;
   } req_beat_type;

   typedef struct packed {
      req_beat_type                  beat;
      logic                          known;
      logic [fau_pkg::OUT_WIDTH-1:0] want;
   } table_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [fau_pkg::REQ_TDATA_W-1:0]      req_tdata;
   logic [fau_pkg::CMD_WIDTH-1:0]        req_tuser;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic [fau_pkg::OUT_WIDTH-1:0]        rsp_tdata;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [fau_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [fau_pkg::CSR_DATA_W-1:0]       csr_data;

   bit [fau_pkg::WORD_WIDTH-1:0]  wt_model   [FEATURE_ROWS*NEURONS];
   bit [fau_pkg::WORD_WIDTH-1:0]  bias_model [NEURONS];
   bit [fau_pkg::WORD_WIDTH-1:0]  acc_model  [2][NEURONS];
   bit [fau_pkg::CLIP_WIDTH-1:0]  clip_model  = fau_pkg::CLIP_RESET;
   bit [fau_pkg::SHIFT_WIDTH-1:0] shift_model = fau_pkg::SHIFT_RESET;

   logic [fau_pkg::OUT_WIDTH-1:0] expected_bytes[$];
   int                   full_rows[$];
   int                   error_count    = 0;
   int                   bytes_taken    = 0;
   int                   cycle_count    = 0;
   bit                   send_burst     = 1'b0;
   bit                   long_hold_done = 1'b0;

   // bias elements 0/64 and 63/127 give fixed products at clip 255, shift 9
   table_row_type directed_tab [DIRECTED_ROWS] = '{
      '{'{CMD_SPARE_6,      1'b1, 1'b1, 12'd4095, 7'd127, 16'hFFFF}, 1'b0, 8'd0},
      '{'{CMD_SPARE_7,      1'b0, 1'b0, 12'd0,    7'd0,   16'h0000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_WEIGHT, 1'b0, 1'b1, 12'd3072, 7'd5,   16'h7FFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_WEIGHT, 1'b1, 1'b0, 12'd4095, 7'd127, 16'h8000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b0, 1'b0, 12'd0,    7'd0,   16'h7FFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b1, 1'b1, 12'd4095, 7'd64,  16'h7FFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b0, 1'b1, 12'd17,   7'd1,   16'h8000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b1, 1'b0, 12'd2048, 7'd65,  16'h7FFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b0, 1'b0, 12'd0,    7'd127, 16'h0010}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_BIAS,   1'b0, 1'b0, 12'd0,    7'd63,  16'h0020}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_SET_BIAS,     1'b0, 1'b1, 12'd4095, 7'd127, 16'hFFFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_SET_BIAS,     1'b1, 1'b0, 12'd0,    7'd0,   16'h0000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b0, 1'b0, 12'd0,    7'd0,   16'h0000}, 1'b1, 8'd127},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b1, 1'b0, 12'd4095, 7'd1,   16'hFFFF}, 1'b1, 8'd0},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b0, 1'b0, 12'd0,    7'd63,  16'h0000}, 1'b1, 8'd1},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b0, 1'b1, 12'd0,    7'd127, 16'h0000}, 1'b1, 8'd1},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b1, 1'b1, 12'd0,    7'd64,  16'h8000}, 1'b1, 8'd127},
      '{'{fau_pkg::CMD_WRITE_WEIGHT, 1'b0, 1'b0, 12'd0,    7'd0,   16'h7FFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_ADD_ROW,      1'b0, 1'b0, 12'd0,    7'd0,   16'h0000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_SUB_ROW,      1'b1, 1'b1, 12'd3071, 7'd127, 16'hFFFF}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_ADD_ROW,      1'b1, 1'b0, 12'd3072, 7'd9,   16'h1234}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_SUB_ROW,      1'b0, 1'b1, 12'd4095, 7'd77,  16'hFEDC}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b0, 1'b0, 12'd0,    7'd0,   16'h0000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_ACTIVATE,     1'b1, 1'b1, 12'd0,    7'd127, 16'h0000}, 1'b0, 8'd0},
      '{'{fau_pkg::CMD_WRITE_WEIGHT, 1'b1, 1'b1, 12'd3071, 7'd127, 16'h8000}, 1'b0, 8'd0}
   };

   feature_accumulator_update_core #(
      .NEURONS      (NEURONS),
      .FEATURE_ROWS (FEATURE_ROWS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("feature_accumulator_update_core_tb: done, errors");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      error_count++;
      $display("%0t ERROR %s", $time, msg);
   endtask

   function automatic int idle_span(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [fau_pkg::WORD_WIDTH-1:0] rand_word();
      int r;
      int v;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      if (r < 5) begin
         v = int'($urandom_range(0, 1535)) - 512;
         return v[15:0];
      end
      return 16'($urandom);
   endfunction

   function automatic req_beat_type noise_beat();
      req_beat_type b;
      b.cmd   = fau_pkg::CMD_ACTIVATE;
      b.persp = 1'($urandom);
      b.stm   = 1'($urandom);
      b.row   = 12'($urandom);
      b.elem  = 7'($urandom);
      b.word  = rand_word();
      return b;
   endfunction

   function automatic logic [fau_pkg::ROW_WIDTH-1:0] pick_full_row();
      return 12'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int r;
      b = noise_beat();
      r = $urandom_range(0, 99);
      if (r < 12) begin
         b.cmd = fau_pkg::CMD_WRITE_WEIGHT;
         b.row = pick_full_row();
      end else if (r < 18) begin
         b.cmd = fau_pkg::CMD_WRITE_WEIGHT;
      end else if (r < 26) begin
         b.cmd = fau_pkg::CMD_WRITE_BIAS;
      end else if (r < 32) begin
         b.cmd = fau_pkg::CMD_SET_BIAS;
      end else if (r < 62) begin
         b.cmd = (r < 48) ? fau_pkg::CMD_ADD_ROW : fau_pkg::CMD_SUB_ROW;
         if ($urandom_range(0, 19) == 0) b.row = 12'($urandom_range(FEATURE_ROWS, 4095));
         else b.row = pick_full_row();
      end else if (r < 97) begin
         b.cmd = fau_pkg::CMD_ACTIVATE;
      end else begin
         b.cmd = r[0] ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      return b;
   endfunction

   function automatic int unsigned clamp_lane(input bit [fau_pkg::WORD_WIDTH-1:0] w);
      if (w[fau_pkg::WORD_WIDTH-1]) return 0;
      if (32'(w) > 32'(clip_model)) return 32'(clip_model);
      return 32'(w);
   endfunction

   function automatic void predict_beat(input req_beat_type b, output bit has_out,
                                        output logic [fau_pkg::OUT_WIDTH-1:0] out_val);
      int          base;
      int          lane;
      bit          side;
      int unsigned prod;
      has_out = 1'b0;
      out_val = '0;
      base    = int'(b.row) * NEURONS;
      case (b.cmd)
         fau_pkg::CMD_WRITE_WEIGHT: begin
            if (int'(b.row) < FEATURE_ROWS && int'(b.elem) < NEURONS)
               wt_model[base + int'(b.elem)] = b.word;
         end
         fau_pkg::CMD_WRITE_BIAS: begin
            if (int'(b.elem) < NEURONS) bias_model[b.elem] = b.word;
         end
         fau_pkg::CMD_SET_BIAS: begin
            for (int i = 0; i < NEURONS; i++) acc_model[b.persp][i] = bias_model[i];
         end
         fau_pkg::CMD_ADD_ROW, fau_pkg::CMD_SUB_ROW: begin
            if (int'(b.row) < FEATURE_ROWS) begin
               for (int i = 0; i < NEURONS; i++) begin
                  if (b.cmd == fau_pkg::CMD_ADD_ROW)
                     acc_model[b.persp][i] = acc_model[b.persp][i] + wt_model[base + i];
                  else
                     acc_model[b.persp][i] = acc_model[b.persp][i] - wt_model[base + i];
               end
            end
         end
         fau_pkg::CMD_ACTIVATE: begin
            has_out = 1'b1;
            if (int'(b.elem) < HALF) begin
               side = b.stm;
               lane = int'(b.elem);
            end else begin
               side = ~b.stm;
               lane = int'(b.elem) - HALF;
            end
            prod = clamp_lane(acc_model[side][lane]) * clamp_lane(acc_model[side][lane + HALF]);
            prod = prod >> shift_model;
            out_val = (prod > 255) ? 8'hFF : prod[7:0];
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input req_beat_type b, input bit known,
                            input logic [fau_pkg::OUT_WIDTH-1:0] want);
      bit                            has_out;
      logic [fau_pkg::OUT_WIDTH-1:0] out_val;
      int                            gap;
      req_tvalid <= 1'b1;
      req_tuser  <= b.cmd;
      req_tdata  <= {3'b000, b.word, b.elem, b.row, b.stm, b.persp};
      do @(posedge clock); while (!req_tready);
      predict_beat(b, has_out, out_val);
      if (has_out) expected_bytes.push_back(known ? want : out_val);
      if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
      gap = idle_span(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [fau_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fau_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == fau_pkg::CSR_CLIP_MAX) clip_model = data[fau_pkg::CLIP_WIDTH-1:0];
      else shift_model = data[fau_pkg::SHIFT_WIDTH-1:0];
   endtask

   task automatic settle();
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_side
      int                            hold_left;
      bit                            burst;
      logic [fau_pkg::OUT_WIDTH-1:0] want;
      hold_left = 0;
      burst     = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            bytes_taken++;
            if (expected_bytes.size() == 0) begin
               flag_error($sformatf("out_byte %0d with nothing pending", rsp_tdata));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want)
                  flag_error($sformatf("out_byte %0d, wanted %0d", rsp_tdata, want));
            end
         end
         if ($urandom_range(0, 49) == 0) burst = !burst;
         if (!long_hold_done && bytes_taken >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            hold_left = idle_span(burst);
            rsp_tready <= (hold_left == 0);
         end
      end
   end

   initial begin : req_side
      req_beat_type                   b;
      logic [fau_pkg::CSR_DATA_W-1:0] phase_clip  [PHASES];
      logic [fau_pkg::CSR_DATA_W-1:0] phase_shift [PHASES];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      phase_clip[1]  = 16'h7FFF;
      phase_shift[1] = 16'h0000;
      phase_clip[2]  = 16'h0001;
      phase_shift[2] = 16'hFFF0;
      phase_clip[3]  = 16'h8000;
      phase_shift[3] = 16'hFFFF;
      phase_clip[4]  = 16'($urandom_range(100, 3000));
      phase_shift[4] = {12'($urandom), 4'($urandom)};
      phase_clip[5]  = 16'h00FF;
      phase_shift[5] = 16'h0009;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // load the whole bias row and a few complete weight rows
      for (int e = 0; e < NEURONS; e++) begin
         b      = noise_beat();
         b.cmd  = fau_pkg::CMD_WRITE_BIAS;
         b.elem = 7'(e);
         send_beat(b, 1'b0, '0);
      end
      full_rows.push_back(0);
      full_rows.push_back(FEATURE_ROWS - 1);
      full_rows.push_back($urandom_range(1, FEATURE_ROWS / 2 - 1));
      full_rows.push_back($urandom_range(FEATURE_ROWS / 2, FEATURE_ROWS - 2));
      foreach (full_rows[k]) begin
         for (int e = 0; e < NEURONS; e++) begin
            b      = noise_beat();
            b.cmd  = fau_pkg::CMD_WRITE_WEIGHT;
            b.row  = 12'(full_rows[k]);
            b.elem = 7'(e);
            send_beat(b, 1'b0, '0);
         end
      end

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_beat(directed_tab[i].beat, directed_tab[i].known, directed_tab[i].want);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            req_tvalid <= 1'b0;
            settle();
            write_csr(fau_pkg::CSR_CLIP_MAX, phase_clip[p]);
            write_csr(fau_pkg::CSR_PRODUCT_SHIFT, phase_shift[p]);
            csr_valid <= 1'b0;
         end
         for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      settle();
      if (error_count == 0) $display("feature_accumulator_update_core_tb: done, clean");
      else $display("feature_accumulator_update_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fau_pkg.sv
rtl/fau_ram.sv
rtl/fau_alu.sv
rtl/feature_accumulator_update_core.sv
dv/feature_accumulator_update_core_tb.sv
